### hdl/mrbps_pkg.sv
`timescale 1ns / 1ps

package mrbps_pkg;

  // Field widths fixed by the register map
  localparam int PERIOD_BITS  = 16;
  localparam int STEP_BITS    = 8;
  localparam int DIGIT_BITS   = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int NUM_TASKS    = 4;

  // Default PWM resolution
  localparam int DUTY_BITS_DEFAULT = 8;

  // Register reset values
  localparam logic [PERIOD_BITS-1:0] BLINK_PERIOD_RST  = 16'd500;
  localparam logic [PERIOD_BITS-1:0] BUZZER_PERIOD_RST = 16'd150;
  localparam logic [PERIOD_BITS-1:0] DIGIT_PERIOD_RST  = 16'd1000;
  localparam logic [PERIOD_BITS-1:0] SCAN_PERIOD_RST   = 16'd200;
  localparam logic [STEP_BITS-1:0]   STEP_RST          = 8'd17;

  // Last digit before wrapping back to zero
  localparam logic [DIGIT_BITS-1:0] DIGIT_LAST = 4'd9;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BLINK_PERIOD  = 3'd0,
    REG_BUZZER_PERIOD = 3'd1,
    REG_DIGIT_PERIOD  = 3'd2,
    REG_SCAN_PERIOD   = 3'd3,
    REG_STEP          = 3'd4
  } cfg_reg_t;

  // Slots of the period counter bank
  typedef enum logic [1:0] {
    TASK_BLINK  = 2'd0,
    TASK_BUZZER = 2'd1,
    TASK_DIGIT  = 2'd2,
    TASK_SCAN   = 2'd3
  } task_t;

endpackage

### hdl/multi_rate_blink_pwm_scheduler_unit.sv
`timescale 1ns / 1ps

// Multi-rate blink / buzzer / digit / brightness scheduler.
//
// Input channel (in_valid / in_stall): one word per millisecond tick,
// carrying the sampled up_pressed and down_pressed button levels.
// Output channel (out_valid / out_stall): one word per tick with the PWM
// duty (brightness while lit, else zero), lit flag, buzzer flag, digit and
// stored brightness level, all as they stand after that tick.
// Configuration channel (cfg_valid / cfg_ready): index and data for the
// four task periods and the brightness step; always ready. The user is to
// write them only while no tick is in flight; the block does not enforce it.
//
// Each accepted tick's word is registered in the output or skid register.
// Throughput is one tick per cycle, set by the single register stage of
// counters and flags; a skid register behind the output register lets one
// more tick in while the receiver stalls, after which in_stall rises.
// Reset loads default periods, clears counters, lights the LED, sets the
// brightness to half scale and empties both output registers.

module multi_rate_blink_pwm_scheduler_unit
  import mrbps_pkg::*;
#(
  parameter int DUTY_BITS = DUTY_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  // tick input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     up_pressed,
  input  logic                     down_pressed,
  // result output
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DUTY_BITS-1:0]     led_duty,
  output logic                     led_lit,
  output logic                     buzzer,
  output logic [DIGIT_BITS-1:0]    digit,
  output logic [DUTY_BITS-1:0]     level,
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int SAT_BITS = ((DUTY_BITS > STEP_BITS) ? DUTY_BITS : STEP_BITS) + 1;
  localparam logic [DUTY_BITS-1:0] DUTY_MAX   = {DUTY_BITS{1'b1}};
  localparam logic [DUTY_BITS-1:0] BRIGHT_RST = DUTY_BITS'(1) << (DUTY_BITS - 1);

  // Configuration registers
  logic [PERIOD_BITS-1:0] period [NUM_TASKS];
  logic [STEP_BITS-1:0]   step_size;

  // Task state
  logic [PERIOD_BITS-1:0] count [NUM_TASKS];
  logic                   lit_flag;
  logic                   buzz_flag;
  logic [DIGIT_BITS-1:0]  shown_digit;
  logic [DUTY_BITS-1:0]   brightness;
  logic                   up_last;
  logic                   down_last;

  // Next-state logic
  logic [PERIOD_BITS-1:0] count_next [NUM_TASKS];
  logic [NUM_TASKS-1:0]   fire;
  logic [PERIOD_BITS:0]   count_inc [NUM_TASKS];
  logic                   lit_next;
  logic                   buzz_next;
  logic [DIGIT_BITS-1:0]  digit_next;
  logic [DUTY_BITS-1:0]   bright_up;
  logic [DUTY_BITS-1:0]   brightness_next;
  logic [SAT_BITS-1:0]    up_sum;
  logic [SAT_BITS-1:0]    down_diff;
  logic [SAT_BITS-1:0]    step_ext;
  logic [SAT_BITS-1:0]    bright_up_ext;
  logic                   up_fresh;
  logic                   down_fresh;
  logic [DUTY_BITS-1:0]   duty_next;

  // Output and skid registers
  logic                   skid_valid;
  logic [DUTY_BITS-1:0]   skid_duty;
  logic                   skid_lit;
  logic                   skid_buzz;
  logic [DIGIT_BITS-1:0]  skid_digit;
  logic [DUTY_BITS-1:0]   skid_level;

  logic                   accept;
  logic                   drain;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign drain     = out_valid && !out_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period[TASK_BLINK]  <= BLINK_PERIOD_RST;
      period[TASK_BUZZER] <= BUZZER_PERIOD_RST;
      period[TASK_DIGIT]  <= DIGIT_PERIOD_RST;
      period[TASK_SCAN]   <= SCAN_PERIOD_RST;
      step_size           <= STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLINK_PERIOD:  period[TASK_BLINK]  <= cfg_data;
        REG_BUZZER_PERIOD: period[TASK_BUZZER] <= cfg_data;
        REG_DIGIT_PERIOD:  period[TASK_DIGIT]  <= cfg_data;
        REG_SCAN_PERIOD:   period[TASK_SCAN]   <= cfg_data;
        REG_STEP:          step_size           <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance period counters; fire and restart once the period is reached
  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      count_inc[i] = {1'b0, count[i]} + (PERIOD_BITS + 1)'(1);
      fire[i]      = count_inc[i] >= {1'b0, period[i]};
      count_next[i] = fire[i] ? '0 : count_inc[i][PERIOD_BITS-1:0];
    end
  end

  // Toggle flags and step the digit
  always_comb begin
    lit_next   = fire[TASK_BLINK]  ? !lit_flag  : lit_flag;
    buzz_next  = fire[TASK_BUZZER] ? !buzz_flag : buzz_flag;
    digit_next = shown_digit;
    if (fire[TASK_DIGIT]) begin
      digit_next = (shown_digit == DIGIT_LAST) ? '0 : shown_digit + DIGIT_BITS'(1);
    end
  end

  // Step brightness on fresh presses, up first, saturating at both ends
  always_comb begin
    up_fresh      = fire[TASK_SCAN] && up_pressed && !up_last;
    down_fresh    = fire[TASK_SCAN] && down_pressed && !down_last;
    step_ext      = SAT_BITS'(step_size);
    up_sum        = SAT_BITS'(brightness) + step_ext;
    bright_up     = brightness;
    if (up_fresh) begin
      bright_up = (up_sum > SAT_BITS'(DUTY_MAX)) ? DUTY_MAX : up_sum[DUTY_BITS-1:0];
    end
    bright_up_ext   = SAT_BITS'(bright_up);
    down_diff       = bright_up_ext - step_ext;
    brightness_next = bright_up;
    if (down_fresh) begin
      brightness_next = (bright_up_ext >= step_ext) ? down_diff[DUTY_BITS-1:0] : '0;
    end
    duty_next = lit_next ? brightness_next : '0;
  end

  // Update task state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        count[i] <= '0;
      end
      lit_flag    <= 1'b1;
      buzz_flag   <= 1'b0;
      shown_digit <= '0;
      brightness  <= BRIGHT_RST;
      up_last     <= 1'b0;
      down_last   <= 1'b0;
    end else if (accept) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        count[i] <= count_next[i];
      end
      lit_flag    <= lit_next;
      buzz_flag   <= buzz_next;
      shown_digit <= digit_next;
      brightness  <= brightness_next;
      if (fire[TASK_SCAN]) begin
        up_last   <= up_pressed;
        down_last <= down_pressed;
      end
    end
  end

  // Output register with skid: load from skid first, else from the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || drain) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payloads; no reset needed
  always_ff @(posedge clk) begin
    if (!out_valid || drain) begin
      if (skid_valid) begin
        led_duty  <= skid_duty;
        led_lit   <= skid_lit;
        buzzer    <= skid_buzz;
        digit     <= skid_digit;
        level     <= skid_level;
      end else if (accept) begin
        led_duty  <= duty_next;
        led_lit   <= lit_next;
        buzzer    <= buzz_next;
        digit     <= digit_next;
        level     <= brightness_next;
      end
    end else if (accept) begin
      skid_duty  <= duty_next;
      skid_lit   <= lit_next;
      skid_buzz  <= buzz_next;
      skid_digit <= digit_next;
      skid_level <= brightness_next;
    end
  end

  // The skid holds a word only behind a full, stalled output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid holds a word while the output register is empty");

  // A dark LED drives no duty
  a_dark_zero_duty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !led_lit) |-> (led_duty == '0))
    else $error("nonzero duty while LED is dark");

  // Duty equals the level while lit
  a_lit_duty_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && led_lit) |-> (led_duty == level))
    else $error("duty differs from level while lit");

  // The displayed digit stays decimal
  a_digit_decimal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit <= DIGIT_LAST))
    else $error("digit out of decimal range");

  // Reset empties both output registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("output not empty after reset");

endmodule
